// File: hdl/qhb_pkg.sv
// Shared types and constants for the quad H-bridge motor command block.
// No dependencies; every other file refers to it by scoped names.
package qhb_pkg;

   // field widths
   localparam int PCT_IN_W   = 16;
   localparam int PCT_W      = 8;
   localparam int MAG_W      = 7;
   localparam int PERIOD_W   = 32;
   localparam int INVERT_W   = 4;
   localparam int MOTOR_W    = 2;
   localparam int MOTOR_COUNT = 4;

   // shared multiplier and the divide-by-100 steps built on it
   localparam int MUL_W      = 32;
   localparam int PROD_W     = 2 * MUL_W;
   localparam int REM_W      = 7;
   localparam int PART_W     = 14;
   localparam logic [MUL_W-1:0] PCT_SCALE   = 32'd100;
   // floor(x / 100) = (x * RECIP_100) >> RECIP_SHIFT for any 32-bit x
   localparam logic [MUL_W-1:0] RECIP_100   = 32'h51EB_851F;
   localparam int               RECIP_SHIFT = 37;
   // floor(y / 100) = (y * PART_RECIP) >> PART_SHIFT for y below 10000
   localparam logic [MUL_W-1:0] PART_RECIP  = 32'd5243;
   localparam int               PART_SHIFT  = 19;

   // saturation limits
   localparam logic signed [PCT_IN_W-1:0] PCT_MAX_IN = 16'sd100;
   localparam logic signed [PCT_IN_W-1:0] PCT_MIN_IN = -16'sd100;
   localparam logic signed [PCT_W-1:0]    PCT_MAX    = 8'sd100;
   localparam logic signed [PCT_W-1:0]    PCT_MIN    = -8'sd100;

   // register file
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;
   localparam logic [PERIOD_W-1:0] PERIOD_RESET = 32'd50000;
   localparam logic [INVERT_W-1:0] INVERT_RESET = 4'd0;

   typedef enum logic {
      CSR_PERIOD = 1'b0,
      CSR_INVERT = 1'b1
   } csr_index_type;

   typedef enum logic {
      CMD_SET  = 1'b0,
      CMD_STOP = 1'b1
   } command_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RECIP,
      ST_REM,
      ST_WHOLE,
      ST_PART,
      ST_FRAC,
      ST_OUT
   } state_type;

endpackage

// File: hdl/qhb_req_if.sv
// Request channel: command and signed left/right percentages.
// Depends on qhb_pkg for field widths.
interface qhb_req_if;
   logic                                valid;
   logic                                ready;
   logic                                command;
   logic signed [qhb_pkg::PCT_IN_W-1:0] left_speed;
   logic signed [qhb_pkg::PCT_IN_W-1:0] right_speed;

   modport source (output valid, command, left_speed, right_speed, input ready);
   modport sink   (input valid, command, left_speed, right_speed, output ready);
endinterface

// File: hdl/qhb_rsp_if.sv
// Result channel: one update per motor.
// Depends on qhb_pkg for field widths.
interface qhb_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [qhb_pkg::MOTOR_W-1:0]         motor_index;
   logic                                pin_a;
   logic                                pin_b;
   logic [qhb_pkg::PERIOD_W-1:0]        pulse_width_ns;
   logic                                reversal_hold;
   logic signed [qhb_pkg::PCT_W-1:0]    applied_pct;
   logic                                last;

   modport source (output valid, motor_index, pin_a, pin_b, pulse_width_ns,
                   reversal_hold, applied_pct, last, input ready);
   modport sink   (input valid, motor_index, pin_a, pin_b, pulse_width_ns,
                   reversal_hold, applied_pct, last, output ready);
endinterface

// File: hdl/quad_hbridge_motor_command.sv
// Four-channel H-bridge direction and PWM command block.
// Depends on qhb_pkg, qhb_req_if and qhb_rsp_if.
//
// Usage:
//   req_chan takes one request: set (left/right percent) or stop all.
//   Percentages are clamped to -100..100; motors 0,1 follow left, 2,3 right.
//   rsp_chan gives four results, motors 0..3 in order, last set on motor 3.
//   Each result: direction pins (invert_mask swaps them, zero coasts),
//   pulse width = period * |pct| / 100, and a reversal flag when the sign
//   flipped directly from the motor's previous applied percent.
// Sequence:
//   One shared 32x32 multiplier under the sequencer. Per request, states
//   RECIP and REM split the period into period/100 (reciprocal multiply)
//   and period%100; per motor, states WHOLE, PART and FRAC build the sum
//   quotient*|pct| + remainder*|pct|/100, then OUT offers the result.
//   No new request is taken until the last result is taken, since
//   req_chan.ready is high only while idle.
// Stall: a result waits in its output register as long as rsp ready is low.
// Reset: stored percents clear to zero, period 50000 ns, invert mask 0.
// Registers (APB, 32-bit): 0x0 pwm_period_ns, 0x4 invert_mask.
module quad_hbridge_motor_command (
   input  logic                              clock,
   input  logic                              reset,
   qhb_req_if.sink                           req_chan,
   qhb_rsp_if.source                         rsp_chan,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [qhb_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [qhb_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [qhb_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                              pready
);

   localparam logic [qhb_pkg::MOTOR_W-1:0] MOTOR_LAST =
      qhb_pkg::MOTOR_W'(qhb_pkg::MOTOR_COUNT - 1);

   // configuration registers
   logic [qhb_pkg::PERIOD_W-1:0] pwm_period_ff;
   logic [qhb_pkg::INVERT_W-1:0] invert_mask_ff;
   logic                         csr_write;
   qhb_pkg::csr_index_type       csr_sel;

   // sequencer and datapath
   qhb_pkg::state_type                state_ff, state_in;
   logic [qhb_pkg::MOTOR_W-1:0]       motor_ff, motor_in;
   logic                              stop_ff, stop_in;
   logic signed [qhb_pkg::PCT_W-1:0]  left_ff, left_in;
   logic signed [qhb_pkg::PCT_W-1:0]  right_ff, right_in;
   logic signed [qhb_pkg::PCT_W-1:0]  last_pct_ff [qhb_pkg::MOTOR_COUNT];
   logic signed [qhb_pkg::PCT_W-1:0]  applied_ff, applied_in;
   logic                              pin_a_ff, pin_a_in;
   logic                              pin_b_ff, pin_b_in;
   logic                              rev_ff, rev_in;
   logic [qhb_pkg::PERIOD_W-1:0]      quo_ff, quo_in;
   logic [qhb_pkg::REM_W-1:0]         rem_ff, rem_in;
   logic [qhb_pkg::PART_W-1:0]        part_ff, part_in;
   logic [qhb_pkg::PERIOD_W-1:0]      work_ff, work_in;
   logic                              pct_write;

   // shared multiplier
   logic [qhb_pkg::MUL_W-1:0]         mul_a;
   logic [qhb_pkg::MUL_W-1:0]         mul_b;
   logic [qhb_pkg::PROD_W-1:0]        mul_p;

   // per-motor combinational terms
   logic signed [qhb_pkg::PCT_W-1:0]  new_pct;
   logic signed [qhb_pkg::PCT_W-1:0]  old_pct;
   logic signed [qhb_pkg::PCT_W-1:0]  neg_pct;
   logic [qhb_pkg::MAG_W-1:0]         mag;
   logic                              fwd;

   // saturate a 16-bit signed percent to -100..100
   function automatic logic signed [qhb_pkg::PCT_W-1:0] sat_pct(
      input logic signed [qhb_pkg::PCT_IN_W-1:0] p);
      logic signed [qhb_pkg::PCT_W-1:0] r;
      if (p > qhb_pkg::PCT_MAX_IN) begin
         r = qhb_pkg::PCT_MAX;
      end else if (p < qhb_pkg::PCT_MIN_IN) begin
         r = qhb_pkg::PCT_MIN;
      end else begin
         r = p[qhb_pkg::PCT_W-1:0];
      end
      return r;
   endfunction

   // APB register file, decoded on the word address
   assign pready    = 1'b1;
   assign csr_write = psel & penable & pwrite;
   assign csr_sel   = qhb_pkg::csr_index_type'(paddr[2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         pwm_period_ff  <= qhb_pkg::PERIOD_RESET;
         invert_mask_ff <= qhb_pkg::INVERT_RESET;
      end else if (csr_write) begin
         unique case (csr_sel)
            qhb_pkg::CSR_PERIOD: pwm_period_ff  <= pwdata;
            qhb_pkg::CSR_INVERT: invert_mask_ff <= pwdata[qhb_pkg::INVERT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_sel)
         qhb_pkg::CSR_PERIOD: prdata = pwm_period_ff;
         qhb_pkg::CSR_INVERT: prdata = {{(qhb_pkg::CSR_DATA_W-qhb_pkg::INVERT_W){1'b0}},
                                        invert_mask_ff};
         default:             prdata = '0;
      endcase
   end

   // percent, direction and magnitude for the current motor
   always_comb begin
      if (stop_ff) begin
         new_pct = '0;
      end else if (motor_ff[1]) begin
         new_pct = right_ff;
      end else begin
         new_pct = left_ff;
      end
      old_pct = last_pct_ff[motor_ff];
      neg_pct = -new_pct;
      mag     = new_pct[qhb_pkg::PCT_W-1] ? neg_pct[qhb_pkg::MAG_W-1:0]
                                          : new_pct[qhb_pkg::MAG_W-1:0];
      fwd     = (new_pct > 0) ^ invert_mask_ff[motor_ff];
   end

   // operand select for the shared multiplier
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         qhb_pkg::ST_RECIP: begin
            mul_a = pwm_period_ff;
            mul_b = qhb_pkg::RECIP_100;
         end
         qhb_pkg::ST_REM: begin
            mul_a = quo_ff;
            mul_b = qhb_pkg::PCT_SCALE;
         end
         qhb_pkg::ST_WHOLE: begin
            mul_a = quo_ff;
            mul_b = {{(qhb_pkg::MUL_W-qhb_pkg::MAG_W){1'b0}}, mag};
         end
         qhb_pkg::ST_PART: begin
            mul_a = {{(qhb_pkg::MUL_W-qhb_pkg::REM_W){1'b0}}, rem_ff};
            mul_b = {{(qhb_pkg::MUL_W-qhb_pkg::MAG_W){1'b0}}, mag};
         end
         qhb_pkg::ST_FRAC: begin
            mul_a = {{(qhb_pkg::MUL_W-qhb_pkg::PART_W){1'b0}}, part_ff};
            mul_b = qhb_pkg::PART_RECIP;
         end
         default: ;
      endcase
   end

   assign mul_p = {{qhb_pkg::MUL_W{1'b0}}, mul_a} * {{qhb_pkg::MUL_W{1'b0}}, mul_b};

   // sequencer: next state and datapath next values
   always_comb begin
      state_in   = state_ff;
      motor_in   = motor_ff;
      stop_in    = stop_ff;
      left_in    = left_ff;
      right_in   = right_ff;
      applied_in = applied_ff;
      pin_a_in   = pin_a_ff;
      pin_b_in   = pin_b_ff;
      rev_in     = rev_ff;
      quo_in     = quo_ff;
      rem_in     = rem_ff;
      part_in    = part_ff;
      work_in    = work_ff;
      pct_write  = 1'b0;
      req_chan.ready = 1'b0;
      rsp_chan.valid = 1'b0;

      unique case (state_ff)
         qhb_pkg::ST_IDLE: begin
            req_chan.ready = 1'b1;
            if (req_chan.valid) begin
               stop_in  = (req_chan.command == qhb_pkg::CMD_STOP);
               left_in  = sat_pct(req_chan.left_speed);
               right_in = sat_pct(req_chan.right_speed);
               motor_in = '0;
               state_in = qhb_pkg::ST_RECIP;
            end
         end
         qhb_pkg::ST_RECIP: begin
            // period / 100 by reciprocal multiply
            quo_in   = {{(qhb_pkg::PERIOD_W+qhb_pkg::RECIP_SHIFT-qhb_pkg::PROD_W){1'b0}},
                        mul_p[qhb_pkg::PROD_W-1:qhb_pkg::RECIP_SHIFT]};
            state_in = qhb_pkg::ST_REM;
         end
         qhb_pkg::ST_REM: begin
            // remainder is below 100, so the low bits suffice
            rem_in   = pwm_period_ff[qhb_pkg::REM_W-1:0] - mul_p[qhb_pkg::REM_W-1:0];
            state_in = qhb_pkg::ST_WHOLE;
         end
         qhb_pkg::ST_WHOLE: begin
            // quotient part, pins and reversal flag; store the new percent
            work_in    = mul_p[qhb_pkg::PERIOD_W-1:0];
            applied_in = new_pct;
            pin_a_in   = (new_pct != 0) & fwd;
            pin_b_in   = (new_pct != 0) & ~fwd;
            rev_in     = ((old_pct > 0) && (new_pct < 0)) ||
                         ((old_pct < 0) && (new_pct > 0));
            pct_write  = 1'b1;
            state_in   = qhb_pkg::ST_PART;
         end
         qhb_pkg::ST_PART: begin
            part_in  = mul_p[qhb_pkg::PART_W-1:0];
            state_in = qhb_pkg::ST_FRAC;
         end
         qhb_pkg::ST_FRAC: begin
            // remainder * |pct| / 100 is at most 99
            work_in  = work_ff + {{(qhb_pkg::PERIOD_W-qhb_pkg::REM_W){1'b0}},
                                  mul_p[qhb_pkg::PART_SHIFT +: qhb_pkg::REM_W]};
            state_in = qhb_pkg::ST_OUT;
         end
         qhb_pkg::ST_OUT: begin
            rsp_chan.valid = 1'b1;
            if (rsp_chan.ready) begin
               if (motor_ff == MOTOR_LAST) begin
                  state_in = qhb_pkg::ST_IDLE;
               end else begin
                  motor_in = motor_ff + 1'b1;
                  state_in = qhb_pkg::ST_WHOLE;
               end
            end
         end
         default: state_in = qhb_pkg::ST_IDLE;
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= qhb_pkg::ST_IDLE;
         motor_ff <= '0;
      end else begin
         state_ff <= state_in;
         motor_ff <= motor_in;
      end
   end

   // stored percent per motor
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < qhb_pkg::MOTOR_COUNT; i++) begin
            last_pct_ff[i] <= '0;
         end
      end else if (pct_write) begin
         last_pct_ff[motor_ff] <= new_pct;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      stop_ff    <= stop_in;
      left_ff    <= left_in;
      right_ff   <= right_in;
      applied_ff <= applied_in;
      pin_a_ff   <= pin_a_in;
      pin_b_ff   <= pin_b_in;
      rev_ff     <= rev_in;
      quo_ff     <= quo_in;
      rem_ff     <= rem_in;
      part_ff    <= part_in;
      work_ff    <= work_in;
   end

   // result fields
   assign rsp_chan.motor_index    = motor_ff;
   assign rsp_chan.pin_a          = pin_a_ff;
   assign rsp_chan.pin_b          = pin_b_ff;
   assign rsp_chan.pulse_width_ns = work_ff;
   assign rsp_chan.reversal_hold  = rev_ff;
   assign rsp_chan.applied_pct    = applied_ff;
   assign rsp_chan.last           = (motor_ff == MOTOR_LAST);

endmodule

// File: tb/tb_quad_hbridge_motor_command.sv
// Self-checking testbench for the quad H-bridge motor command block.
// Depends on qhb_pkg, qhb_req_if, qhb_rsp_if and quad_hbridge_motor_command.
// Directed table, then random commands across several register settings.
module tb_quad_hbridge_motor_command;

   // per-group values typed into the directed table
   typedef struct packed {
      logic                             pin_a;
      logic                             pin_b;
      logic [qhb_pkg::PERIOD_W-1:0]     pulse;
      logic                             reversal;
      logic signed [qhb_pkg::PCT_W-1:0] pct;
   } group_want_type;

   typedef struct packed {
      qhb_pkg::command_type                cmd;
      logic signed [qhb_pkg::PCT_IN_W-1:0] left_speed;
      logic signed [qhb_pkg::PCT_IN_W-1:0] right_speed;
      logic                                typed;
      group_want_type                      left_want;
      group_want_type                      right_want;
   } stim_row_type;

   typedef struct {
      logic [qhb_pkg::MOTOR_W-1:0]      motor_index;
      logic                             pin_a;
      logic                             pin_b;
      logic [qhb_pkg::PERIOD_W-1:0]     pulse_width_ns;
      logic                             reversal_hold;
      logic signed [qhb_pkg::PCT_W-1:0] applied_pct;
      logic                             last;
   } motor_update_type;

   localparam group_want_type COAST = '0;
   localparam int DIRECTED_COUNT = 21;
   localparam int PHASE_COUNT = 6;
   localparam int PHASE_ITEMS = 17;

   // after reset: period 50000, no inversion
   localparam stim_row_type DIRECTED_ROWS [DIRECTED_COUNT] = '{
      '{qhb_pkg::CMD_SET,  16'sd0,      16'sd0,      1'b1, COAST, COAST},
      '{qhb_pkg::CMD_SET,  16'sd100,    -16'sd100,   1'b1,
        '{1'b1, 1'b0, 32'd50000, 1'b0, 8'sd100}, '{1'b0, 1'b1, 32'd50000, 1'b0, -8'sd100}},
      '{qhb_pkg::CMD_SET,  -16'sd100,   16'sd100,    1'b1,
        '{1'b0, 1'b1, 32'd50000, 1'b1, -8'sd100}, '{1'b1, 1'b0, 32'd50000, 1'b1, 8'sd100}},
      '{qhb_pkg::CMD_SET,  16'sd32767,  -16'sd32768, 1'b1,
        '{1'b1, 1'b0, 32'd50000, 1'b1, 8'sd100}, '{1'b0, 1'b1, 32'd50000, 1'b1, -8'sd100}},
      '{qhb_pkg::CMD_STOP, 16'sd55,     -16'sd77,    1'b1, COAST, COAST},
      '{qhb_pkg::CMD_SET,  -16'sd32768, 16'sd32767,  1'b1,
        '{1'b0, 1'b1, 32'd50000, 1'b0, -8'sd100}, '{1'b1, 1'b0, 32'd50000, 1'b0, 8'sd100}},
      '{qhb_pkg::CMD_SET,  16'sd101,    -16'sd101,   1'b1,
        '{1'b1, 1'b0, 32'd50000, 1'b1, 8'sd100}, '{1'b0, 1'b1, 32'd50000, 1'b1, -8'sd100}},
      '{qhb_pkg::CMD_SET,  16'sd1,      -16'sd1,     1'b1,
        '{1'b1, 1'b0, 32'd500, 1'b0, 8'sd1}, '{1'b0, 1'b1, 32'd500, 1'b0, -8'sd1}},
      '{qhb_pkg::CMD_SET,  -16'sd1,     16'sd1,      1'b1,
        '{1'b0, 1'b1, 32'd500, 1'b1, -8'sd1}, '{1'b1, 1'b0, 32'd500, 1'b1, 8'sd1}},
      '{qhb_pkg::CMD_SET,  16'sd0,      16'sd0,      1'b1, COAST, COAST},
      '{qhb_pkg::CMD_SET,  -16'sd101,   16'sd99,     1'b0, COAST, COAST},
      '{qhb_pkg::CMD_SET,  16'sd50,     16'sd0,      1'b0, COAST, COAST},
      '{qhb_pkg::CMD_SET,  16'sd0,      -16'sd50,    1'b0, COAST, COAST},
      '{qhb_pkg::CMD_SET,  -16'sd32767, 16'sd32766,  1'b0, COAST, COAST},
      '{qhb_pkg::CMD_SET,  16'sd256,    -16'sd256,   1'b0, COAST, COAST},
      '{qhb_pkg::CMD_SET,  16'sd37,     -16'sd63,    1'b0, COAST, COAST},
      '{qhb_pkg::CMD_STOP, -16'sd1,     -16'sd1,     1'b0, COAST, COAST},
      '{qhb_pkg::CMD_STOP, 16'sd0,      16'sd0,      1'b0, COAST, COAST},
      '{qhb_pkg::CMD_SET,  -16'sd7,     16'sd13,     1'b0, COAST, COAST},
      '{qhb_pkg::CMD_SET,  16'sd128,    -16'sd128,   1'b0, COAST, COAST},
      '{qhb_pkg::CMD_SET,  16'sd99,     -16'sd99,    1'b0, COAST, COAST}
   };

   // register settings per random phase; the last two are drawn at run time
   localparam logic [qhb_pkg::PERIOD_W-1:0] PERIOD_STEPS [4] =
      '{32'hFFFF_FFFF, 32'd1, 32'd0, 32'd100};
   localparam logic [qhb_pkg::INVERT_W-1:0] INVERT_STEPS [4] = '{4'hF, 4'h0, 4'h5, 4'hA};

   logic clock;
   logic reset;
   logic psel;
   logic penable;
   logic pwrite;
   logic [qhb_pkg::CSR_ADDR_W-1:0] paddr;
   logic [qhb_pkg::CSR_DATA_W-1:0] pwdata;
   logic [qhb_pkg::CSR_DATA_W-1:0] prdata;
   logic pready;

   qhb_req_if req_chan ();
   qhb_rsp_if rsp_chan ();

   quad_hbridge_motor_command dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   // predictor state and register shadow
   logic signed [qhb_pkg::PCT_W-1:0] motor_pct_state [qhb_pkg::MOTOR_COUNT];
   logic [qhb_pkg::PERIOD_W-1:0]     period_setting;
   logic [qhb_pkg::INVERT_W-1:0]     invert_setting;

   motor_update_type expected_updates [$];
   int  mismatch_count = 0;
   int  stall_cycles = 0;
   bit  no_gaps = 1'b0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // mostly back to back, some short gaps, a few long ones
   function automatic int idle_cycles();
      int r;
      if (no_gaps)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 60)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic signed [qhb_pkg::PCT_IN_W-1:0] random_pct();
      int r;
      int v;
      r = $urandom_range(0, 99);
      if (r < 45)
         v = int'($urandom_range(0, 200)) - 100;
      else if (r < 65)
         v = (int'($urandom_range(0, 2)) - 1) * 100;
      else if (r < 75)
         v = int'($urandom_range(0, 6)) - 3;
      else
         v = int'($urandom);
      return v[qhb_pkg::PCT_IN_W-1:0];
   endfunction

   function automatic logic signed [qhb_pkg::PCT_W-1:0] clamp_pct(
      logic signed [qhb_pkg::PCT_IN_W-1:0] p);
      if (p > qhb_pkg::PCT_MAX_IN)
         return qhb_pkg::PCT_MAX;
      if (p < qhb_pkg::PCT_MIN_IN)
         return qhb_pkg::PCT_MIN;
      return p[qhb_pkg::PCT_W-1:0];
   endfunction

   // walk the four motors, derive each update and advance the stored percents
   function automatic void predict_motor_updates(
      input qhb_pkg::command_type cmd,
      input logic signed [qhb_pkg::PCT_IN_W-1:0] l_pct,
      input logic signed [qhb_pkg::PCT_IN_W-1:0] r_pct,
      output motor_update_type upd [qhb_pkg::MOTOR_COUNT]);
      logic signed [qhb_pkg::PCT_W-1:0] old_pct;
      logic signed [qhb_pkg::PCT_W-1:0] new_pct;
      logic [qhb_pkg::PCT_W-1:0]        mag;
      logic [63:0]                      product;
      logic                             fwd;
      for (int m = 0; m < qhb_pkg::MOTOR_COUNT; m++) begin
         old_pct = motor_pct_state[m];
         if (cmd == qhb_pkg::CMD_STOP)
            new_pct = '0;
         else
            new_pct = (m < 2) ? clamp_pct(l_pct) : clamp_pct(r_pct);
         fwd = (new_pct > 0) ^ invert_setting[m];
         mag = (new_pct < 0) ? -new_pct : new_pct;
         product = {32'b0, period_setting} * {56'b0, mag};
         upd[m].motor_index    = m[qhb_pkg::MOTOR_W-1:0];
         upd[m].pin_a          = (new_pct != 0) && fwd;
         upd[m].pin_b          = (new_pct != 0) && !fwd;
         upd[m].pulse_width_ns = 32'(product / 64'd100);
         upd[m].reversal_hold  = (old_pct > 0 && new_pct < 0) || (old_pct < 0 && new_pct > 0);
         upd[m].applied_pct    = new_pct;
         upd[m].last           = (m == qhb_pkg::MOTOR_COUNT - 1);
         motor_pct_state[m]    = new_pct;
      end
   endfunction

   // APB write: setup cycle, then access cycle
   task automatic write_register(input qhb_pkg::csr_index_type idx,
                                 input logic [qhb_pkg::CSR_DATA_W-1:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      if (idx == qhb_pkg::CSR_PERIOD)
         period_setting = data;
      else
         invert_setting = data[qhb_pkg::INVERT_W-1:0];
   endtask

   // send one request; queue its four updates once it is taken
   task automatic issue_command(input qhb_pkg::command_type cmd,
                                input logic signed [qhb_pkg::PCT_IN_W-1:0] l_pct,
                                input logic signed [qhb_pkg::PCT_IN_W-1:0] r_pct,
                                input bit end_of_burst,
                                input bit typed,
                                input group_want_type l_want,
                                input group_want_type r_want);
      motor_update_type upd [qhb_pkg::MOTOR_COUNT];
      group_want_type   w;
      int               gap;
      req_chan.valid       <= 1'b1;
      req_chan.command     <= cmd;
      req_chan.left_speed  <= l_pct;
      req_chan.right_speed <= r_pct;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      predict_motor_updates(cmd, l_pct, r_pct, upd);
      for (int m = 0; m < qhb_pkg::MOTOR_COUNT; m++) begin
         // typed rows override what the predictor gives, state still advances
         if (typed) begin
            w = (m < 2) ? l_want : r_want;
            upd[m].pin_a          = w.pin_a;
            upd[m].pin_b          = w.pin_b;
            upd[m].pulse_width_ns = w.pulse;
            upd[m].reversal_hold  = w.reversal;
            upd[m].applied_pct    = w.pct;
         end
         expected_updates.push_back(upd[m]);
      end
      gap = idle_cycles();
      if (gap > 0 || end_of_burst) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   function automatic void check_field(input string name, input logic [63:0] want,
                                       input logic [63:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, got);
         mismatch_count++;
      end
   endfunction

   task automatic check_motor_update();
      motor_update_type want;
      if (expected_updates.size() == 0) begin
         $display("%0t: unexpected motor update for motor %0d", $time, rsp_chan.motor_index);
         mismatch_count++;
      end else begin
         want = expected_updates.pop_front();
         check_field("motor_index", want.motor_index, rsp_chan.motor_index);
         check_field("pin_a", want.pin_a, rsp_chan.pin_a);
         check_field("pin_b", want.pin_b, rsp_chan.pin_b);
         check_field("pulse_width_ns", want.pulse_width_ns, rsp_chan.pulse_width_ns);
         check_field("reversal_hold", want.reversal_hold, rsp_chan.reversal_hold);
         check_field("applied_pct", want.applied_pct, rsp_chan.applied_pct);
         check_field("last", want.last, rsp_chan.last);
      end
   endtask

   // result side: check taken updates, stall ready at random
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready)
         check_motor_update();
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else if (stall_cycles > 0) begin
         stall_cycles--;
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= 1'b1;
         stall_cycles = idle_cycles();
      end
   end

   // main sequence
   initial begin
      qhb_pkg::command_type             cmd;
      logic [qhb_pkg::PERIOD_W-1:0]     period;
      logic [qhb_pkg::INVERT_W-1:0]     mask;
      reset                <= 1'b1;
      psel                 <= 1'b0;
      penable              <= 1'b0;
      pwrite               <= 1'b0;
      paddr                <= '0;
      pwdata               <= '0;
      req_chan.valid       <= 1'b0;
      req_chan.command     <= qhb_pkg::CMD_SET;
      req_chan.left_speed  <= '0;
      req_chan.right_speed <= '0;
      period_setting = qhb_pkg::PERIOD_RESET;
      invert_setting = qhb_pkg::INVERT_RESET;
      for (int m = 0; m < qhb_pkg::MOTOR_COUNT; m++)
         motor_pct_state[m] = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table at reset settings
      for (int i = 0; i < DIRECTED_COUNT; i++)
         issue_command(DIRECTED_ROWS[i].cmd, DIRECTED_ROWS[i].left_speed,
                       DIRECTED_ROWS[i].right_speed, i == DIRECTED_COUNT - 1,
                       DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].left_want,
                       DIRECTED_ROWS[i].right_want);

      // random phases, registers rewritten only once the block has drained
      for (int p = 0; p < PHASE_COUNT; p++) begin
         while (expected_updates.size() != 0) @(posedge clock);
         repeat (3) @(posedge clock);
         no_gaps = (p == 1);
         period = (p < 4) ? PERIOD_STEPS[p] : qhb_pkg::PERIOD_W'($urandom);
         mask   = (p < 4) ? INVERT_STEPS[p] : qhb_pkg::INVERT_W'($urandom);
         write_register(qhb_pkg::CSR_PERIOD, period);
         write_register(qhb_pkg::CSR_INVERT, {28'($urandom), mask});
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            cmd = ($urandom_range(0, 99) < 15) ? qhb_pkg::CMD_STOP : qhb_pkg::CMD_SET;
            issue_command(cmd, random_pct(), random_pct(), k == PHASE_ITEMS - 1,
                          1'b0, COAST, COAST);
         end
      end

      while (expected_updates.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (mismatch_count == 0 && expected_updates.size() == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

   // hang guard
   initial begin
      #5000000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule

// File: files.f
hdl/qhb_pkg.sv
hdl/qhb_req_if.sv
hdl/qhb_rsp_if.sv
hdl/quad_hbridge_motor_command.sv
tb/tb_quad_hbridge_motor_command.sv
